// ----- design/bmes_pkg.sv -----
// ----------------------------------------------------------------------------
// bmes_pkg - shared types and helpers for the BMES Viterbi tagger
// Score format, tag and register codes, predecessor tables and the
// saturating three-term score sum.
// ----------------------------------------------------------------------------
package bmes_pkg;

  localparam int unsigned MAX_LEN_DEF = 64;
  localparam int unsigned SCORE_W     = 32;
  localparam int unsigned N_CFG       = 8;
  localparam int unsigned CFG_IDX_W   = 3;

  typedef logic signed [SCORE_W-1:0] score_t;
  typedef score_t [3:0]              score_vec_t;
  typedef score_t [N_CFG-1:0]        cfg_vec_t;

  localparam score_t SCORE_IMPOSSIBLE = {1'b1, {(SCORE_W-1){1'b0}}};
  localparam score_t SCORE_MAX        = {1'b0, {(SCORE_W-1){1'b1}}};
  localparam score_t SCORE_MIN_POSS   = {1'b1, {(SCORE_W-2){1'b0}}, 1'b1};

  // tags / states
  localparam logic [1:0] TAG_B = 2'd0;
  localparam logic [1:0] TAG_M = 2'd1;
  localparam logic [1:0] TAG_E = 2'd2;
  localparam logic [1:0] TAG_S = 2'd3;

  // transition register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_B_TO_M = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_B_TO_E = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_M_TO_M = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_M_TO_E = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_E_TO_B = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_E_TO_S = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_S_TO_B = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_S_TO_S = 3'd7;

  typedef struct packed {
    score_vec_t  score;
    logic [3:0]  bp;
  } acs_res_t;

  // predecessor of state st; sel picks first (0) or second (1) listed
  function automatic logic [1:0] pred_state(input logic [1:0] st, input logic sel);
    logic [1:0] p;
    case (st)
      TAG_B:   p = sel ? TAG_S : TAG_E;
      TAG_M:   p = sel ? TAG_B : TAG_M;
      TAG_E:   p = sel ? TAG_M : TAG_B;
      TAG_S:   p = sel ? TAG_E : TAG_S;
      default: p = TAG_S;
    endcase
    return p;
  endfunction

  // register holding the transition from that predecessor into st
  function automatic logic [CFG_IDX_W-1:0] trans_reg(input logic [1:0] st,
                                                     input logic sel);
    logic [CFG_IDX_W-1:0] r;
    case (st)
      TAG_B:   r = sel ? CFG_S_TO_B : CFG_E_TO_B;
      TAG_M:   r = sel ? CFG_B_TO_M : CFG_M_TO_M;
      TAG_E:   r = sel ? CFG_M_TO_E : CFG_B_TO_E;
      TAG_S:   r = sel ? CFG_E_TO_S : CFG_S_TO_S;
      default: r = CFG_S_TO_S;
    endcase
    return r;
  endfunction

  // impossible if any term is; otherwise saturate to the possible range
  function automatic score_t add3(input score_t a, input score_t b, input score_t c);
    logic signed [SCORE_W+1:0] s;
    score_t r;
    s = (SCORE_W+2)'(a) + (SCORE_W+2)'(b) + (SCORE_W+2)'(c);
    if (a == SCORE_IMPOSSIBLE || b == SCORE_IMPOSSIBLE || c == SCORE_IMPOSSIBLE) begin
      r = SCORE_IMPOSSIBLE;
    end else if (s > (SCORE_W+2)'(SCORE_MAX)) begin
      r = SCORE_MAX;
    end else if (s < (SCORE_W+2)'(SCORE_MIN_POSS)) begin
      r = SCORE_MIN_POSS;
    end else begin
      r = s[SCORE_W-1:0];
    end
    return r;
  endfunction

endpackage

// ----- design/bmes_acs.sv -----
// ----------------------------------------------------------------------------
// bmes_acs - add-compare-select for the four BMES states
// Forms both candidate sums per state and keeps the strictly greater one,
// reporting the choice as one backpointer bit per state.
// ----------------------------------------------------------------------------
module bmes_acs
  import bmes_pkg::*;
(
  input  score_vec_t score_i,
  input  score_vec_t emit_i,
  input  cfg_vec_t   cfg_i,
  output acs_res_t   res_o
);

  score_t     c0, c1;
  logic [1:0] st;

  always_comb begin
    res_o = '0;
    st    = '0;
    for (int k = 0; k < 4; k++) begin
      st = 2'(k);
      c0 = add3(score_i[pred_state(st, 1'b0)], cfg_i[trans_reg(st, 1'b0)],
                emit_i[st]);
      c1 = add3(score_i[pred_state(st, 1'b1)], cfg_i[trans_reg(st, 1'b1)],
                emit_i[st]);
      // ties and double-impossible keep the first predecessor
      res_o.bp[st]    = $signed(c1) > $signed(c0);
      res_o.score[st] = res_o.bp[st] ? c1 : c0;
    end
  end

endmodule

// ----- design/bmes_store.sv -----
// ----------------------------------------------------------------------------
// bmes_store - backpointer and tag memories
// Two single-write, single-read memories with registered read data.
// ----------------------------------------------------------------------------
module bmes_store
  import bmes_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic                       clk_i,
  input  logic                       bp_we_i,
  input  logic [$clog2(MAX_LEN)-1:0] bp_waddr_i,
  input  logic [3:0]                 bp_wdata_i,
  input  logic [$clog2(MAX_LEN)-1:0] bp_raddr_i,
  output logic [3:0]                 bp_rdata_o,
  input  logic                       tag_we_i,
  input  logic [$clog2(MAX_LEN)-1:0] tag_waddr_i,
  input  logic [1:0]                 tag_wdata_i,
  input  logic [$clog2(MAX_LEN)-1:0] tag_raddr_i,
  output logic [1:0]                 tag_rdata_o
);

  logic [3:0] bp_mem  [MAX_LEN];
  logic [1:0] tag_mem [MAX_LEN];

  always_ff @(posedge clk_i) begin
    if (bp_we_i) begin
      bp_mem[bp_waddr_i] <= bp_wdata_i;
    end
    bp_rdata_o <= bp_mem[bp_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (tag_we_i) begin
      tag_mem[tag_waddr_i] <= tag_wdata_i;
    end
    tag_rdata_o <= tag_mem[tag_raddr_i];
  end

endmodule

// ----- design/bmes_viterbi_tagger_core.sv -----
// ----------------------------------------------------------------------------
// bmes_viterbi_tagger_core - four-state BMES Viterbi tagger
// Forward recursion per character, backpointers in memory, traceback into
// a tag memory and in-order streaming of the tags of each sentence.
// ----------------------------------------------------------------------------
//  channel   | direction | word contents
//  s_axis    | in        | tdata: emit_begin, emit_middle, emit_end, emit_single;
//            |           | tlast: last_char
//  m_axis    | out       | tdata: tag, best_score; tlast: tag_last; tuser: overflow
//  cfg       | in        | write enable, register index 0..7, 32-bit value
//
//  Each character is taken in ST_IDLE, then ST_FWD does the add-compare-select
//  and the backpointer write. After the last character come ST_FINAL and the
//  traceback in ST_TRACE (one backpointer memory read per position), ST_PRIME,
//  then one tag per cycle in ST_EMIT while m_axis_tready holds. No input word
//  is taken between the last character and the final tag leaving the tag
//  memory. Reset clears the state, cfg, scores, position, overflow and output valid.
// ----------------------------------------------------------------------------
module bmes_viterbi_tagger_core
  import bmes_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [127:0]         s_axis_tdata,  // emit_begin, emit_middle, emit_end, emit_single
  input  logic                 s_axis_tlast,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // tag, best_score, zero pad
  output logic                 m_axis_tlast,
  output logic                 m_axis_tuser,  // overflow
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SCORE_W-1:0]   cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_LEN);
  localparam int unsigned PW = $clog2(MAX_LEN + 1);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_FWD   = 6'b000010,
    ST_FINAL = 6'b000100,
    ST_TRACE = 6'b001000,
    ST_PRIME = 6'b010000,
    ST_EMIT  = 6'b100000
  } state_e;

  state_e     state_q, state_d;
  cfg_vec_t   cfg_q;
  score_vec_t emit_q;
  logic       last_q;
  score_vec_t score_q, score_d;
  logic [PW-1:0] pos_q, pos_d;
  logic       ovf_q, ovf_d;
  score_t     best_q, best_d;
  logic       sovf_q, sovf_d;
  logic [AW-1:0] lidx_q, lidx_d;
  logic [AW-1:0] tpos_q, tpos_d;
  logic [1:0] tst_q, tst_d;
  logic [AW-1:0] eidx_q, eidx_d;
  logic       oval_q, oval_d;
  logic [1:0] otag_q, otag_d;
  logic       olast_q, olast_d;
  score_t     obest_q, obest_d;
  logic       oovf_q, oovf_d;

  acs_res_t   acs_res;
  logic [PW-1:0] pos_m1;
  logic       take_s;
  logic       load;

  logic          bp_we;
  logic [AW-1:0] bp_raddr;
  logic [3:0]    bp_rdata;
  logic          tag_we;
  logic [AW-1:0] tag_raddr;
  logic [1:0]    tag_rdata;

  bmes_acs u_acs (
    .score_i (score_q),
    .emit_i  (emit_q),
    .cfg_i   (cfg_q),
    .res_o   (acs_res)
  );

  bmes_store #(
    .MAX_LEN (MAX_LEN)
  ) u_store (
    .clk_i       (clk_i),
    .bp_we_i     (bp_we),
    .bp_waddr_i  (pos_q[AW-1:0]),
    .bp_wdata_i  (acs_res.bp),
    .bp_raddr_i  (bp_raddr),
    .bp_rdata_o  (bp_rdata),
    .tag_we_i    (tag_we),
    .tag_waddr_i (tpos_q),
    .tag_wdata_i (tst_q),
    .tag_raddr_i (tag_raddr),
    .tag_rdata_o (tag_rdata)
  );

  assign pos_m1 = pos_q - PW'(1);
  // E unless S is strictly better or E is impossible
  assign take_s = ($signed(score_q[TAG_S]) > $signed(score_q[TAG_E])) ||
                  (score_q[TAG_E] == SCORE_IMPOSSIBLE);
  assign load   = (state_q == ST_EMIT) && (!oval_q || m_axis_tready);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = oval_q;
  assign m_axis_tdata  = {6'd0, obest_q, otag_q};
  assign m_axis_tlast  = olast_q;
  assign m_axis_tuser  = oovf_q;

  always_comb begin
    state_d  = state_q;
    score_d  = score_q;
    pos_d    = pos_q;
    ovf_d    = ovf_q;
    best_d   = best_q;
    sovf_d   = sovf_q;
    lidx_d   = lidx_q;
    tpos_d   = tpos_q;
    tst_d    = tst_q;
    eidx_d   = eidx_q;
    oval_d   = oval_q;
    otag_d   = otag_q;
    olast_d  = olast_q;
    obest_d  = obest_q;
    oovf_d   = oovf_q;
    bp_we    = 1'b0;
    tag_we   = 1'b0;
    bp_raddr = tpos_q - AW'(1);
    tag_raddr = '0;

    if (oval_q && m_axis_tready) begin
      oval_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_FWD;
        end
      end
      ST_FWD: begin
        if (pos_q >= PW'(MAX_LEN)) begin
          ovf_d = 1'b1;
        end else if (pos_q == '0) begin
          score_d = emit_q;
          pos_d   = PW'(1);
        end else begin
          score_d = acs_res.score;
          bp_we   = 1'b1;
          pos_d   = pos_q + PW'(1);
        end
        state_d = last_q ? ST_FINAL : ST_IDLE;
      end
      ST_FINAL: begin
        // latch sentence results, start the backpointer read, clear for next
        best_d   = take_s ? score_q[TAG_S] : score_q[TAG_E];
        tst_d    = take_s ? TAG_S : TAG_E;
        sovf_d   = ovf_q;
        lidx_d   = pos_m1[AW-1:0];
        tpos_d   = pos_m1[AW-1:0];
        bp_raddr = pos_m1[AW-1:0];
        score_d  = '0;
        pos_d    = '0;
        ovf_d    = 1'b0;
        state_d  = ST_TRACE;
      end
      ST_TRACE: begin
        tag_we = 1'b1;
        if (tpos_q == '0) begin
          state_d = ST_PRIME;
        end else begin
          tst_d  = pred_state(tst_q, bp_rdata[tst_q]);
          tpos_d = tpos_q - AW'(1);
        end
      end
      ST_PRIME: begin
        eidx_d  = '0;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        tag_raddr = load ? (eidx_q + AW'(1)) : eidx_q;
        if (load) begin
          oval_d  = 1'b1;
          otag_d  = tag_rdata;
          olast_d = (eidx_q == lidx_q);
          obest_d = best_q;
          oovf_d  = sovf_q;
          eidx_d  = eidx_q + AW'(1);
          if (eidx_q == lidx_q) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cfg_q   <= '0;
      score_q <= '0;
      pos_q   <= '0;
      ovf_q   <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      score_q <= score_d;
      pos_q   <= pos_d;
      ovf_q   <= ovf_d;
      oval_q  <= oval_d;
      if (cfg_we_i) begin
        cfg_q[cfg_idx_i] <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      emit_q <= s_axis_tdata;
      last_q <= s_axis_tlast;
    end
    best_q  <= best_d;
    sovf_q  <= sovf_d;
    lidx_q  <= lidx_d;
    tpos_q  <= tpos_d;
    tst_q   <= tst_d;
    eidx_q  <= eidx_d;
    otag_q  <= otag_d;
    olast_q <= olast_d;
    obest_q <= obest_d;
    oovf_q  <= oovf_d;
  end

endmodule

// ----- sim/bmes_viterbi_tag_checker.sv -----
// ----------------------------------------------------------------------------
// bmes_viterbi_tag_checker - tag stream checker for the BMES Viterbi tagger
// Watches the character, tag and register channels. It keeps its own copy of
// the transition table and of the path scores and backpointers. From these
// it works out the tags of each sentence. Each tag word that leaves the block
// is compared with the oldest tag still owed.
// ----------------------------------------------------------------------------
module bmes_viterbi_tag_checker
  import bmes_pkg::*;
#(
  parameter int unsigned MAX_LEN = MAX_LEN_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  input  logic                 s_axis_tready,
  input  logic [127:0]         s_axis_tdata,  // emit_begin, emit_middle, emit_end, emit_single
  input  logic                 s_axis_tlast,
  input  logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  input  logic [39:0]          m_axis_tdata,  // tag, best_score, zero pad
  input  logic                 m_axis_tlast,
  input  logic                 m_axis_tuser,  // overflow
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SCORE_W-1:0]   cfg_data_i,
  output int                   fail_count_o,
  output int                   pending_o
);

  typedef struct packed {
    logic [1:0] tag;
    logic       last;
    score_t     best;
    logic       ovf;
  } tag_word_t;

  // index {state, second}: the predecessor and the register of its transition
  localparam logic [7:0][1:0] PRED_OF = {
    TAG_E, TAG_S, TAG_M, TAG_B, TAG_B, TAG_M, TAG_S, TAG_E
  };
  localparam logic [7:0][CFG_IDX_W-1:0] TRANS_OF = {
    CFG_E_TO_S, CFG_S_TO_S, CFG_M_TO_E, CFG_B_TO_E,
    CFG_B_TO_M, CFG_M_TO_M, CFG_S_TO_B, CFG_E_TO_B
  };

  score_t     trans_tbl [N_CFG];
  score_t     path [4];
  logic [3:0] bp_mem [MAX_LEN];
  int         fill;
  logic       truncated;
  tag_word_t  tags_owed [$];
  int         errors;

  assign fail_count_o = errors;

  // any impossible term makes the sum impossible; a possible sum saturates short of impossible
  function automatic score_t sum3(input score_t a, input score_t b, input score_t c);
    longint acc;
    if (a == SCORE_IMPOSSIBLE || b == SCORE_IMPOSSIBLE || c == SCORE_IMPOSSIBLE) begin
      return SCORE_IMPOSSIBLE;
    end
    acc = longint'(a) + longint'(b) + longint'(c);
    if (acc > longint'(SCORE_MAX)) begin
      acc = longint'(SCORE_MAX);
    end else if (acc < longint'(SCORE_MIN_POSS)) begin
      acc = longint'(SCORE_MIN_POSS);
    end
    return acc[SCORE_W-1:0];
  endfunction

  task automatic take_char(input logic [127:0] data, input logic last);
    score_t     nxt [4];
    score_t     e;
    score_t     cand;
    score_t     best;
    logic [3:0] bp;
    logic [1:0] st;
    logic [1:0] tags [MAX_LEN];
    tag_word_t  w;
    if (fill >= MAX_LEN) begin
      truncated = 1'b1;
    end else if (fill == 0) begin
      for (int s = 0; s < 4; s++) begin
        path[s] = data[32*s +: 32];
      end
      fill = 1;
    end else begin
      for (int s = 0; s < 4; s++) begin
        e = data[32*s +: 32];
        nxt[s] = SCORE_IMPOSSIBLE;
        bp[s] = 1'b0;
        // first listed predecessor keeps a tie
        for (int p = 0; p < 2; p++) begin
          cand = sum3(path[PRED_OF[2*s+p]], trans_tbl[TRANS_OF[2*s+p]], e);
          if (cand > nxt[s]) begin
            nxt[s] = cand;
            bp[s] = p[0];
          end
        end
      end
      for (int s = 0; s < 4; s++) begin
        path[s] = nxt[s];
      end
      bp_mem[fill] = bp;
      fill++;
    end
    if (last) begin
      best = SCORE_IMPOSSIBLE;
      st = TAG_S;
      if (path[TAG_E] > best) begin
        best = path[TAG_E];
        st = TAG_E;
      end
      if (path[TAG_S] > best) begin
        best = path[TAG_S];
        st = TAG_S;
      end
      for (int i = fill; i > 0; i--) begin
        tags[i-1] = st;
        if (i > 1) begin
          st = PRED_OF[{st, bp_mem[i-1][st]}];
        end
      end
      for (int i = 0; i < fill; i++) begin
        w.tag = tags[i];
        w.last = (i + 1 == fill);
        w.best = best;
        w.ovf = truncated;
        tags_owed.insert(tags_owed.size(), w);
      end
      for (int s = 0; s < 4; s++) begin
        path[s] = '0;
      end
      fill = 0;
      truncated = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    tag_word_t want;
    if (!rst_ni) begin
      for (int r = 0; r < N_CFG; r++) begin
        trans_tbl[r] = '0;
      end
      for (int s = 0; s < 4; s++) begin
        path[s] = '0;
      end
      fill = 0;
      truncated = 1'b0;
      errors = 0;
      tags_owed.delete();
      pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (tags_owed.size() == 0) begin
          errors++;
          $error("tag word with no sentence owed: tag %0d", m_axis_tdata[1:0]);
        end else begin
          want = tags_owed.pop_front();
          if (m_axis_tdata[1:0] !== want.tag) begin
            errors++;
            $error("tag: expected %0d, got %0d", want.tag, m_axis_tdata[1:0]);
          end
          if (m_axis_tlast !== want.last) begin
            errors++;
            $error("tag_last: expected %0d, got %0d", want.last, m_axis_tlast);
          end
          if (m_axis_tdata[33:2] !== want.best) begin
            errors++;
            $error("best_score: expected %0d, got %0d", $signed(want.best),
                   $signed(m_axis_tdata[33:2]));
          end
          if (m_axis_tuser !== want.ovf) begin
            errors++;
            $error("overflow: expected %0d, got %0d", want.ovf, m_axis_tuser);
          end
        end
      end
      if (cfg_we_i) begin
        trans_tbl[cfg_idx_i] = cfg_data_i;
      end
      if (s_axis_tvalid && s_axis_tready) begin
        take_char(s_axis_tdata, s_axis_tlast);
      end
      pending_o <= tags_owed.size();
    end
  end

endmodule

// ----- sim/tb_bmes_viterbi_tagger_core.sv -----
// ----------------------------------------------------------------------------
// tb_bmes_viterbi_tagger_core - testbench for the BMES Viterbi tagger core
// Feeds sentences of emission scores under several transition tables, from
// lone characters up to sentences that run past the backpointer store, with
// random gaps on the character side and random stalls on the tag side.
// A checker beside the block predicts every tag word and counts mismatches.
// ----------------------------------------------------------------------------
module tb_bmes_viterbi_tagger_core
  import bmes_pkg::*;
();

  localparam int IDLE_PCT       = 14;
  localparam int SETTLE_CYCLES  = 8;
  localparam int DRAIN_CYCLES   = MAX_LEN_DEF + 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SHORT_ITEMS    = 17;

  typedef enum int {
    TBL_TYPICAL, TBL_NO_PATHS, TBL_ALL_MAX, TBL_RANDOM, TBL_MIXED, TBL_FLOOR, N_TABLES
  } table_kind_e;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [127:0]         s_axis_tdata = '0;  // emit_begin, emit_middle, emit_end, emit_single
  logic                 s_axis_tlast = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;       // tag, best_score, zero pad
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;       // overflow
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [SCORE_W-1:0]   cfg_data_i = '0;

  int   fail_count;
  int   pending;
  logic calm = 1'b0;
  int   quiet = 0;
  int   tags_seen = 0;
  int   chars = 0;
  int   sentences = 0;
  int   truncated_runs = 0;
  int   run_len = 0;
  int   tables = 0;

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  bmes_viterbi_tagger_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  bmes_viterbi_tag_checker tag_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      tags_seen <= tags_seen + 1;
    end
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet <= 0;
    end else if (quiet >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d tags owed", quiet, pending);
      $display("status: fail");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  function automatic logic [127:0] pack4(input score_t b, input score_t m, input score_t e,
                                         input score_t s);
    return {s, e, m, b};
  endfunction

  // mostly moderate log scores, now and then the extremes or any bit pattern
  function automatic score_t pick_score();
    case ($urandom_range(15))
      0:       return SCORE_IMPOSSIBLE;
      1:       return SCORE_MAX;
      2:       return SCORE_MIN_POSS;
      3, 4:    return $urandom;
      default: return -score_t'($urandom_range(12 << 16));
    endcase
  endfunction

  function automatic cfg_vec_t make_table(input table_kind_e kind);
    cfg_vec_t tbl;
    case (kind)
      TBL_TYPICAL: begin
        tbl[CFG_B_TO_M] = -32'sd72090;
        tbl[CFG_B_TO_E] = -32'sd26214;
        tbl[CFG_M_TO_M] = -32'sd58982;
        tbl[CFG_M_TO_E] = -32'sd32768;
        tbl[CFG_E_TO_B] = -32'sd39322;
        tbl[CFG_E_TO_S] = -32'sd52429;
        tbl[CFG_S_TO_B] = -32'sd45875;
        tbl[CFG_S_TO_S] = -32'sd45875;
      end
      TBL_NO_PATHS: tbl = {N_CFG{SCORE_IMPOSSIBLE}};
      TBL_ALL_MAX:  tbl = {N_CFG{SCORE_MAX}};
      TBL_RANDOM: begin
        for (int r = 0; r < N_CFG; r++) begin
          tbl[r] = $urandom;
        end
      end
      TBL_MIXED: begin
        for (int r = 0; r < N_CFG; r++) begin
          case ($urandom_range(3))
            0:       tbl[r] = SCORE_IMPOSSIBLE;
            1:       tbl[r] = SCORE_MIN_POSS;
            2:       tbl[r] = SCORE_MAX;
            default: tbl[r] = -score_t'($urandom_range(4 << 16));
          endcase
        end
      end
      default: tbl = {N_CFG{SCORE_MIN_POSS}};
    endcase
    return tbl;
  endfunction

  task automatic send_char(input logic [127:0] emits, input logic last);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= emits;
    s_axis_tlast  <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    chars++;
    run_len++;
    if (last) begin
      sentences++;
      if (run_len > MAX_LEN_DEF) begin
        truncated_runs++;
      end
      run_len = 0;
    end
  endtask

  task automatic send_sentence(input int len);
    for (int i = 0; i < len; i++) begin
      send_char(pack4(pick_score(), pick_score(), pick_score(), pick_score()), i == len - 1);
    end
  endtask

  // drop valid, wait for the last tag and the block to settle, then write
  task automatic load_table(input cfg_vec_t tbl);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    for (int r = 0; r < N_CFG; r++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(r);
      cfg_data_i <= tbl[r];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    tables++;
  endtask

  initial begin : stimulus
    int budget;
    int len;
    table_kind_e kind;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lone characters: E wins, E and S tie, neither possible
    send_char(pack4('0, '0, 32'sh0005_0000, 32'sh0003_0000), 1'b1);
    send_char(pack4(SCORE_MAX, SCORE_IMPOSSIBLE, 32'sh0007_0000, 32'sh0007_0000), 1'b1);
    send_char(pack4(SCORE_MAX, SCORE_MAX, SCORE_IMPOSSIBLE, SCORE_IMPOSSIBLE), 1'b1);
    // saturate at the top, then at the bottom without turning impossible
    send_char(pack4(SCORE_MAX, SCORE_MAX, SCORE_MAX, SCORE_MAX), 1'b0);
    send_char(pack4(SCORE_MAX, SCORE_MAX, SCORE_MAX, SCORE_MAX), 1'b1);
    send_char(pack4(SCORE_MIN_POSS, SCORE_MIN_POSS, SCORE_MIN_POSS, SCORE_MIN_POSS), 1'b0);
    send_char(pack4(SCORE_MIN_POSS, SCORE_MIN_POSS, SCORE_MIN_POSS, SCORE_MIN_POSS), 1'b0);
    send_char(pack4(SCORE_MIN_POSS, SCORE_MIN_POSS, SCORE_MIN_POSS, SCORE_MIN_POSS), 1'b1);
    // one path only: S B M E S
    send_char(pack4(SCORE_IMPOSSIBLE, SCORE_IMPOSSIBLE, SCORE_IMPOSSIBLE, '0), 1'b0);
    send_char(pack4('0, SCORE_IMPOSSIBLE, SCORE_IMPOSSIBLE, SCORE_IMPOSSIBLE), 1'b0);
    send_char(pack4(SCORE_IMPOSSIBLE, '0, SCORE_IMPOSSIBLE, SCORE_IMPOSSIBLE), 1'b0);
    send_char(pack4(SCORE_IMPOSSIBLE, SCORE_IMPOSSIBLE, '0, SCORE_IMPOSSIBLE), 1'b0);
    send_char(pack4(SCORE_IMPOSSIBLE, SCORE_IMPOSSIBLE, SCORE_IMPOSSIBLE, 32'shFFFF_FFFF),
              1'b1);
    // flat scores leave every choice a tie
    send_char(pack4('0, '0, '0, '0), 1'b0);
    send_char(pack4('0, '0, '0, '0), 1'b0);
    send_char(pack4(32'shFFFF_FFFF, 32'sh0000_0001, 32'sh5555_5555, 32'shAAAA_AAAA), 1'b1);

    for (int t = 0; t < N_TABLES; t++) begin
      kind = table_kind_e'(t);
      load_table(make_table(kind));
      calm <= (kind == TBL_RANDOM);
      budget = SHORT_ITEMS;
      while (budget > 0) begin
        len = $urandom_range(1, 10);
        send_sentence(len);
        budget -= len;
      end
      if (kind == TBL_TYPICAL) begin
        send_sentence(MAX_LEN_DEF);
      end
      if (kind == TBL_MIXED) begin
        send_sentence(MAX_LEN_DEF + 1 + $urandom_range(3));
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d characters in %0d sentences, %0d of them past the store",
             chars, sentences, truncated_runs);
    $display("under %0d transition tables; %0d tag words checked", tables + 1, tags_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
